// ===== hdl/clsr_pkg.sv =====
// Shared types and constants of the character display shadow refresh block.
// Used by clsr_front, clsr_back and the top level; depends on nothing.
package clsr_pkg;

    localparam int LINE_COLS  = 16;
    localparam int SHADOW_LEN = 2 * LINE_COLS;
    localparam int ADDR_W     = $clog2(SHADOW_LEN);
    localparam int POS_W      = $clog2(SHADOW_LEN + 1);
    localparam int FILL_W     = $clog2(LINE_COLS + 1);
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] ADDR_LINE2 = 8'hC0;
    localparam logic [7:0] CMD_HOME   = 8'h02;
    localparam logic [7:0] PAD_CHAR   = 8'h20;
    localparam logic [7:0] CH_END     = 8'h00;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CHAR  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       line2;
        logic [7:0] ch;
    } t_item;

endpackage

// ===== hdl/clsr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package is used.
module clsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/clsr_front.sv =====
// Front end: accepts input transactions, drops those that have no effect and
// queues the rest for the back end. Depends on clsr_pkg.
module clsr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_cmd,
    input  logic                i_busy_req,
    input  logic [1:0]          i_line,
    input  logic [7:0]          i_ch,
    output logic                o_q_valid,
    output clsr_pkg::t_item     o_q_item,
    input  logic                i_q_pop
);

    clsr_pkg::t_item                 r_q [clsr_pkg::Q_DEPTH];
    logic [clsr_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [clsr_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [clsr_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            keep;
    logic                            push;
    clsr_pkg::t_item                 item;

    always_comb begin
        keep    = 1'b0;
        item.op = clsr_pkg::OP_TICK;
        unique case (clsr_pkg::t_cmd'(i_cmd))
            clsr_pkg::CMD_TICK: begin
                keep    = !i_busy_req;
                item.op = clsr_pkg::OP_TICK;
            end
            clsr_pkg::CMD_CHAR: begin
                keep    = (i_line == clsr_pkg::LINE_ONE) || (i_line == clsr_pkg::LINE_TWO);
                item.op = clsr_pkg::OP_CHAR;
            end
            clsr_pkg::CMD_CLEAR: begin
                keep    = 1'b1;
                item.op = clsr_pkg::OP_CLEAR;
            end
            default: begin
                keep    = 1'b0;
                item.op = clsr_pkg::OP_TICK;
            end
        endcase
        item.line2 = (i_line == clsr_pkg::LINE_TWO);
        item.ch    = i_ch;
    end

    assign o_ready   = (r_count != clsr_pkg::QCNT_W'(clsr_pkg::Q_DEPTH));
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

endmodule

// ===== hdl/clsr_back.sv =====
// Back end: owns the shadow RAM, the refresh position and the string fill
// state, and drives the output register. Depends on clsr_pkg and clsr_ram.
module clsr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  clsr_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_reg_select,
    output logic [7:0]          o_lcd_byte
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_SWEEP = 3'b100
    } t_state;

    localparam int AW = clsr_pkg::ADDR_W;
    localparam int PW = clsr_pkg::POS_W;
    localparam int FW = clsr_pkg::FILL_W;

    t_state                          r_state, n_state;
    logic [PW-1:0]                   r_read_pos, n_read_pos;
    logic                            r_cursor_pending, n_cursor_pending;
    logic [FW-1:0]                   r_fill, n_fill;
    logic [AW-1:0]                   r_sw_addr, n_sw_addr;
    logic [AW-1:0]                   r_sw_end, n_sw_end;
    logic [AW-1:0]                   r_rd_addr, n_rd_addr;
    logic [clsr_pkg::SHADOW_LEN-1:0] r_valid, n_valid;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_rs, n_out_rs;
    logic [7:0]                      r_out_byte, n_out_byte;

    logic          slot_free;
    logic [AW-1:0] base;
    logic [AW-1:0] char_addr;
    logic [AW-1:0] pad_end;
    logic [AW-1:0] tick_pos;
    logic [PW-1:0] next_pos;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;

    assign slot_free = !r_out_valid || i_ready;
    assign base      = i_q_item.line2 ? AW'(clsr_pkg::LINE_COLS) : '0;
    assign char_addr = base + AW'(r_fill);
    assign pad_end   = base + AW'(clsr_pkg::LINE_COLS - 1);
    assign tick_pos  = (r_read_pos >= PW'(clsr_pkg::SHADOW_LEN)) ? '0 : r_read_pos[AW-1:0];
    assign next_pos  = PW'(r_rd_addr) + 1'b1;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid
                       && ((i_q_item.op != clsr_pkg::OP_TICK) || slot_free);

    always_comb begin
        n_state          = r_state;
        n_read_pos       = r_read_pos;
        n_cursor_pending = r_cursor_pending;
        n_fill           = r_fill;
        n_sw_addr        = r_sw_addr;
        n_sw_end         = r_sw_end;
        n_rd_addr        = r_rd_addr;
        n_valid          = r_valid;
        n_out_valid      = r_out_valid && !i_ready;
        n_out_rs         = r_out_rs;
        n_out_byte       = r_out_byte;
        we               = 1'b0;
        waddr            = r_sw_addr;
        wdata            = clsr_pkg::PAD_CHAR;

        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    unique case (i_q_item.op)
                        clsr_pkg::OP_TICK: begin
                            if (r_cursor_pending) begin
                                n_cursor_pending = 1'b0;
                                n_out_valid      = 1'b1;
                                n_out_rs         = clsr_pkg::RS_CMD;
                                if (r_read_pos == PW'(clsr_pkg::LINE_COLS)) begin
                                    n_out_byte = clsr_pkg::ADDR_LINE2;
                                end else begin
                                    n_out_byte = clsr_pkg::CMD_HOME;
                                    n_read_pos = '0;
                                end
                            end else begin
                                n_rd_addr = tick_pos;
                                n_state   = S_READ;
                            end
                        end
                        clsr_pkg::OP_CHAR: begin
                            if (i_q_item.ch == clsr_pkg::CH_END) begin
                                n_fill = '0;
                                if (r_fill < FW'(clsr_pkg::LINE_COLS)) begin
                                    n_sw_addr = char_addr;
                                    n_sw_end  = pad_end;
                                    n_state   = S_SWEEP;
                                end
                            end else if (r_fill < FW'(clsr_pkg::LINE_COLS)) begin
                                we                 = 1'b1;
                                waddr              = char_addr;
                                wdata              = i_q_item.ch;
                                n_valid[char_addr] = 1'b1;
                                n_fill             = r_fill + 1'b1;
                            end
                        end
                        clsr_pkg::OP_CLEAR: begin
                            n_sw_addr = '0;
                            n_sw_end  = AW'(clsr_pkg::SHADOW_LEN - 1);
                            n_state   = S_SWEEP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_rs    = clsr_pkg::RS_DATA;
                n_out_byte  = r_valid[r_rd_addr] ? rdata : 8'h00;
                n_read_pos  = next_pos;
                if ((next_pos == PW'(clsr_pkg::LINE_COLS))
                    || (next_pos == PW'(clsr_pkg::SHADOW_LEN))) begin
                    n_cursor_pending = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_SWEEP: begin
                we                 = 1'b1;
                waddr              = r_sw_addr;
                wdata              = clsr_pkg::PAD_CHAR;
                n_valid[r_sw_addr] = 1'b1;
                n_sw_addr          = r_sw_addr + 1'b1;
                if (r_sw_addr == r_sw_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_read_pos       <= '0;
            r_cursor_pending <= 1'b0;
            r_fill           <= '0;
            r_valid          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_read_pos       <= n_read_pos;
            r_cursor_pending <= n_cursor_pending;
            r_fill           <= n_fill;
            r_valid          <= n_valid;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_addr  <= n_sw_addr;
        r_sw_end   <= n_sw_end;
        r_rd_addr  <= n_rd_addr;
        r_out_rs   <= n_out_rs;
        r_out_byte <= n_out_byte;
    end

    clsr_ram #(
        .WIDTH (8),
        .DEPTH (clsr_pkg::SHADOW_LEN)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (tick_pos),
        .o_rdata (rdata)
    );

    assign o_valid      = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_lcd_byte   = r_out_byte;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_pos <= PW'(clsr_pkg::SHADOW_LEN))
        else $error("Refresh position has run past the end of the shadow.");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(clsr_pkg::LINE_COLS))
        else $error("String fill count has run past the end of a line.");

    a_cursor_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor_pending |-> ((r_read_pos == PW'(clsr_pkg::LINE_COLS))
                              || (r_read_pos == PW'(clsr_pkg::SHADOW_LEN))))
        else $error("Cursor command pending away from a line end.");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("Shadow read finishing while the output register is occupied.");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != S_IDLE) || !$stable(r_out_valid) || $past(i_q_item.op)
                    != clsr_pkg::OP_TICK || r_out_valid)
        else $error("Refresh tick taken from the queue without any effect.");

endmodule

// ===== hdl/char_lcd_shadow_refresh.sv =====
// Top level of the character display shadow refresh block.
// Depends on clsr_pkg, clsr_front and clsr_back.
//
// Keeps a shadow of a two-line display and, on each non-busy refresh tick,
// emits one bus transfer: the next shadow character as data, or a cursor
// command (line-2 address after line 1, return home after line 2). A
// two-entry queue sits between the input front end and the back end, so
// the input side takes transactions while the back end works. In the back
// end a data tick reads the shadow RAM (one read port) in READ, a cursor tick
// or stored character is handled in IDLE, a terminating zero pads the rest
// of its line (up to LINE_COLS columns) and a clear all 2*LINE_COLS columns
// in SWEEP, one column per cycle, as the shadow RAM has one write port.
// Busy ticks, unused commands and characters for lines other than 1 or 2
// are dropped at the input. Results wait in an output register until taken.
module char_lcd_shadow_refresh (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // busy_req [0], line [2:1], ch [10:3], zeros above
    input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // lcd_byte [7:0]
    output logic        m_axis_tuser    // reg_select [0]
);

    logic            q_valid;
    logic            q_pop;
    clsr_pkg::t_item q_item;

    clsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_busy_req (s_axis_tdata[0]),
        .i_line     (s_axis_tdata[2:1]),
        .i_ch       (s_axis_tdata[10:3]),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    clsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_reg_select (m_axis_tuser),
        .o_lcd_byte   (m_axis_tdata)
    );

endmodule
